// ----- rtl/core/urbe_pkg.sv -----
// ----------------------------------------------------------------------------
// urbe_pkg
// Shared types and constants of the UART ring buffer engine.
// ----------------------------------------------------------------------------
package urbe_pkg;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int SIZE_W    = 9;
    localparam int ERRCNT_W  = 32;
    localparam int CFG_IDX_W = 1;
    localparam int ACTION_W  = 2;

    // default store depth and ring length after reset
    localparam int            RING_DEPTH_DEF = 256;
    localparam logic [SIZE_W-1:0] SIZE_RST   = 9'd256;

    // host / service actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_SERVICE = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_READ    = 2'd2,
        ACT_PURGE   = 2'd3
    } t_action;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RX_SIZE = 1'b0,
        CFG_TX_SIZE = 1'b1
    } t_cfg_idx;

    // pointer commands into one ring
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_ring_cmd;

    // ring status: flags on the current pointers, counts after the command
    typedef struct packed {
        logic              empty;
        logic              full;
        logic [BYTE_W-1:0] count;
        logic [BYTE_W-1:0] free;
    } t_ring_stat;

endpackage

// ----- rtl/core/urbe_ram.sv -----
// ----------------------------------------------------------------------------
// urbe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module urbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/core/urbe_ring.sv -----
// ----------------------------------------------------------------------------
// urbe_ring
// Read and write positions of one ring, its length in use, full and empty
// flags, and the occupancy and free space after the current command.
// ----------------------------------------------------------------------------
module urbe_ring #(
    parameter int RING_DEPTH = urbe_pkg::RING_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [urbe_pkg::SIZE_W-1:0]   i_size,
    input  urbe_pkg::t_ring_cmd           i_cmd,
    output urbe_pkg::t_ring_stat          o_stat,
    output logic [$clog2(RING_DEPTH)-1:0] o_wr_pos,
    output logic [$clog2(RING_DEPTH)-1:0] o_rd_pos
);
    import urbe_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int LEN_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;

    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [PTR_W-1:0] wr_inc, rd_inc;
    logic [LEN_W-1:0] len;
    logic [CMP_W-1:0] size_x;
    logic [BYTE_W-1:0] w8, r8, l8, cnt8;

    // next position, wrapping at the length in use (also after a shrink)
    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] pos,
                                              input logic [LEN_W-1:0] ln);
        logic [LEN_W-1:0] nx;
        nx = LEN_W'(pos) + LEN_W'(1);
        return (nx >= ln) ? '0 : PTR_W'(nx);
    endfunction

    // clamp the programmed length to 2..RING_DEPTH
    assign size_x = CMP_W'(i_size);
    always_comb begin
        priority if (size_x < CMP_W'(2)) begin
            len = LEN_W'(2);
        end else if (size_x > CMP_W'(RING_DEPTH)) begin
            len = LEN_W'(RING_DEPTH);
        end else begin
            len = LEN_W'(size_x);
        end
    end

    assign wr_inc = adv(r_wr, len);
    assign rd_inc = adv(r_rd, len);

    // pointer update
    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        priority if (i_cmd.clear) begin
            n_wr = '0;
            n_rd = '0;
        end else begin
            if (i_cmd.push) n_wr = wr_inc;
            if (i_cmd.pop)  n_rd = rd_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    // counts after the update; only the low byte is reported, so work mod 256
    assign w8 = BYTE_W'(n_wr);
    assign r8 = BYTE_W'(n_rd);
    assign l8 = BYTE_W'(len);
    always_comb begin
        priority if (n_wr == n_rd) begin
            cnt8 = '0;
        end else if (n_wr < n_rd) begin
            cnt8 = w8 + l8 - r8;
        end else begin
            cnt8 = w8 - r8;
        end
    end

    assign o_stat.empty = (r_wr == r_rd);
    assign o_stat.full  = (wr_inc == r_rd);
    assign o_stat.count = cnt8;
    assign o_stat.free  = l8 - BYTE_W'(1) - cnt8;
    assign o_wr_pos     = r_wr;
    assign o_rd_pos     = r_rd;

endmodule

// ----- rtl/core/uart_ring_buffer_engine.sv -----
// ----------------------------------------------------------------------------
// uart_ring_buffer_engine
// UART receive and transmit rings with host access and error counters.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall| action, byte, line flags
//  out     | output    | o_out_valid/i_out_stall| send/read/write status, counts
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  An item is accepted in S_IDLE, while both ring stores are read at their
//  oldest entries; S_EXEC uses the registered read data to update the rings,
//  pointers and counters and load the result register.
//  The update waits while a previous result is still stalled in the output
//  register; a new item is accepted while a result waits.
//  Reset is synchronous; the stores need no clearing pass.
// ----------------------------------------------------------------------------
module uart_ring_buffer_engine #(
    parameter int RING_DEPTH = urbe_pkg::RING_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [urbe_pkg::ACTION_W-1:0]    i_action,
    input  logic [urbe_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                             i_byte_present,
    input  logic                             i_tx_ready,
    input  logic                             i_framing_error,
    input  logic                             i_parity_error,
    input  logic                             i_noise_error,
    input  logic                             i_overrun_error,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_send_valid,
    output logic [urbe_pkg::BYTE_W-1:0]      o_send_byte,
    output logic                             o_read_valid,
    output logic [urbe_pkg::BYTE_W-1:0]      o_read_byte,
    output logic                             o_write_accepted,
    output logic                             o_tx_request_on,
    output logic [urbe_pkg::BYTE_W-1:0]      o_rx_count,
    output logic [urbe_pkg::BYTE_W-1:0]      o_tx_free,
    output logic [urbe_pkg::ERRCNT_W-1:0]    o_framing_errors,
    output logic [urbe_pkg::ERRCNT_W-1:0]    o_parity_errors,
    output logic [urbe_pkg::ERRCNT_W-1:0]    o_noise_errors,
    output logic [urbe_pkg::ERRCNT_W-1:0]    o_overrun_errors,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [urbe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [urbe_pkg::SIZE_W-1:0]      i_cfg_data
);
    import urbe_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;

    // captured item
    t_action           r_action;
    logic [BYTE_W-1:0] r_data;
    logic              r_present, r_ready;
    logic              r_fe, r_pe, r_ne, r_oe;

    // configuration and flop state
    logic [SIZE_W-1:0]   r_rx_size, r_tx_size;
    logic                r_tx_req, n_tx_req;
    logic [ERRCNT_W-1:0] r_fe_cnt, r_pe_cnt, r_ne_cnt, r_oe_cnt;
    logic [ERRCNT_W-1:0] n_fe_cnt, n_pe_cnt, n_ne_cnt, n_oe_cnt;

    // rings and stores
    t_ring_cmd        rx_cmd, tx_cmd;
    t_ring_stat       rx_stat, tx_stat;
    logic [PTR_W-1:0] rx_wr_pos, rx_rd_pos, tx_wr_pos, tx_rd_pos;
    logic [BYTE_W-1:0] rx_q, tx_q;

    // result
    logic              commit;
    logic              n_send_valid, n_read_valid, n_write_ok;
    logic [BYTE_W-1:0] n_send_byte, n_read_byte;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign commit      = (r_state == S_EXEC) && (!o_out_valid || !i_out_stall);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_size <= SIZE_RST;
            r_tx_size <= SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RX_SIZE: r_rx_size <= i_cfg_data;
                CFG_TX_SIZE: r_tx_size <= i_cfg_data;
            endcase
        end
    end

    // ring pointer control
    urbe_ring #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_size   (r_rx_size),
        .i_cmd    (rx_cmd),
        .o_stat   (rx_stat),
        .o_wr_pos (rx_wr_pos),
        .o_rd_pos (rx_rd_pos)
    );

    urbe_ring #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_size   (r_tx_size),
        .i_cmd    (tx_cmd),
        .o_stat   (tx_stat),
        .o_wr_pos (tx_wr_pos),
        .o_rd_pos (tx_rd_pos)
    );

    // ring stores: always read at the oldest entry, written at the newest
    urbe_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_cmd.push),
        .i_waddr (rx_wr_pos),
        .i_wdata (r_data),
        .i_raddr (rx_rd_pos),
        .o_rdata (rx_q)
    );

    urbe_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_cmd.push),
        .i_waddr (tx_wr_pos),
        .i_wdata (r_data),
        .i_raddr (tx_rd_pos),
        .o_rdata (tx_q)
    );

    // action decode and state update, only on commit
    always_comb begin
        rx_cmd       = '0;
        tx_cmd       = '0;
        n_tx_req     = r_tx_req;
        n_fe_cnt     = r_fe_cnt;
        n_pe_cnt     = r_pe_cnt;
        n_ne_cnt     = r_ne_cnt;
        n_oe_cnt     = r_oe_cnt;
        n_send_valid = 1'b0;
        n_send_byte  = '0;
        n_read_valid = 1'b0;
        n_read_byte  = '0;
        n_write_ok   = 1'b0;
        if (commit) begin
            unique case (r_action)
                ACT_SERVICE: begin
                    if (r_fe) n_fe_cnt = r_fe_cnt + ERRCNT_W'(1);
                    if (r_pe) n_pe_cnt = r_pe_cnt + ERRCNT_W'(1);
                    if (r_ne) n_ne_cnt = r_ne_cnt + ERRCNT_W'(1);
                    if (r_oe) n_oe_cnt = r_oe_cnt + ERRCNT_W'(1);
                    rx_cmd.push = r_present && !rx_stat.full;
                    if (r_ready) begin
                        if (tx_stat.empty) begin
                            n_tx_req = 1'b0;
                        end else begin
                            tx_cmd.pop   = 1'b1;
                            n_send_valid = 1'b1;
                            n_send_byte  = tx_q;
                        end
                    end
                end
                ACT_WRITE: begin
                    if (!tx_stat.full) begin
                        tx_cmd.push = 1'b1;
                        n_tx_req    = 1'b1;
                        n_write_ok  = 1'b1;
                    end
                end
                ACT_READ: begin
                    if (!rx_stat.empty) begin
                        rx_cmd.pop   = 1'b1;
                        n_read_valid = 1'b1;
                        n_read_byte  = rx_q;
                    end
                end
                ACT_PURGE: begin
                    rx_cmd.clear = 1'b1;
                end
            endcase
        end
    end

    // sequencer, item capture and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tx_req    <= 1'b1;
            r_fe_cnt    <= '0;
            r_pe_cnt    <= '0;
            r_ne_cnt    <= '0;
            r_oe_cnt    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_tx_req <= n_tx_req;
            r_fe_cnt <= n_fe_cnt;
            r_pe_cnt <= n_pe_cnt;
            r_ne_cnt <= n_ne_cnt;
            r_oe_cnt <= n_oe_cnt;
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_EXEC;
                S_EXEC: if (commit)     r_state <= S_IDLE;
            endcase
            if (commit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action  <= t_action'(i_action);
            r_data    <= i_data_byte;
            r_present <= i_byte_present;
            r_ready   <= i_tx_ready;
            r_fe      <= i_framing_error;
            r_pe      <= i_parity_error;
            r_ne      <= i_noise_error;
            r_oe      <= i_overrun_error;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (commit) begin
            o_send_valid     <= n_send_valid;
            o_send_byte      <= n_send_byte;
            o_read_valid     <= n_read_valid;
            o_read_byte      <= n_read_byte;
            o_write_accepted <= n_write_ok;
            o_tx_request_on  <= n_tx_req;
            o_rx_count       <= rx_stat.count;
            o_tx_free        <= tx_stat.free;
            o_framing_errors <= n_fe_cnt;
            o_parity_errors  <= n_pe_cnt;
            o_noise_errors   <= n_ne_cnt;
            o_overrun_errors <= n_oe_cnt;
        end
    end

    // checks
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !commit)
        else $error("result register overwritten while stalled");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted item not taken into execution");

    a_one_host_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_write_accepted && o_read_valid))
        else $error("write and read reported in one result");

    a_write_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_accepted) |-> o_tx_request_on)
        else $error("accepted write left transmit request off");

endmodule

// ----- tb/urbe_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// urbe_tb_pkg
// Transfer types and the ring tracker used by the UART ring buffer testbench.
// The tracker mirrors both rings, the request flag and the error counters,
// works out the status each input transfer should produce and checks the
// status transfers coming back in order.
// ----------------------------------------------------------------------------
package urbe_tb_pkg;

    import urbe_pkg::*;

    // one input transfer
    typedef struct {
        t_action             action;
        logic [BYTE_W-1:0]   data;
        logic                present;
        logic                tx_ready;
        logic                framing;
        logic                parity;
        logic                noise;
        logic                overrun;
    } uart_item_t;

    // one status transfer
    typedef struct {
        logic                send_valid;
        logic [BYTE_W-1:0]   send_byte;
        logic                read_valid;
        logic [BYTE_W-1:0]   read_byte;
        logic                write_ok;
        logic                tx_request;
        logic [BYTE_W-1:0]   rx_count;
        logic [BYTE_W-1:0]   tx_free;
        logic [ERRCNT_W-1:0] framing;
        logic [ERRCNT_W-1:0] parity;
        logic [ERRCNT_W-1:0] noise;
        logic [ERRCNT_W-1:0] overrun;
    } uart_status_t;

    class uart_ring_tracker;

        // mirrored ring contents and which entries hold a real byte
        logic [BYTE_W-1:0]       rx_mem [RING_DEPTH_DEF];
        logic [BYTE_W-1:0]       tx_mem [RING_DEPTH_DEF];
        bit [RING_DEPTH_DEF-1:0] rx_known;
        bit [RING_DEPTH_DEF-1:0] tx_known;

        int unsigned             rx_wp, rx_rp, tx_wp, tx_rp;
        logic                    tx_req;
        logic [ERRCNT_W-1:0]     fe_cnt, pe_cnt, ne_cnt, oe_cnt;
        logic [SIZE_W-1:0]       rx_size, tx_size;

        uart_status_t            status_q [$];
        int                      errors;

        function new();
            rx_known = '0;
            tx_known = '0;
            rx_wp    = 0;
            rx_rp    = 0;
            tx_wp    = 0;
            tx_rp    = 0;
            tx_req   = 1'b1;
            fe_cnt   = '0;
            pe_cnt   = '0;
            ne_cnt   = '0;
            oe_cnt   = '0;
            rx_size  = SIZE_RST;
            tx_size  = SIZE_RST;
            errors   = 0;
        endfunction

        // length in use, clamped to the store
        function int unsigned ring_len(logic [SIZE_W-1:0] size);
            if (size < 2)
                return 2;
            if (size > RING_DEPTH_DEF)
                return RING_DEPTH_DEF;
            return size;
        endfunction

        // positions at or past the length wrap to zero
        function int unsigned next_pos(int unsigned pos, int unsigned len);
            return (pos + 1 >= len) ? 0 : pos + 1;
        endfunction

        function void set_size(t_cfg_idx idx, logic [SIZE_W-1:0] size);
            if (idx == CFG_RX_SIZE)
                rx_size = size;
            else
                tx_size = size;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        // steer away from entries that were never filled
        function uart_item_t make_safe(uart_item_t it);
            if (it.action == ACT_READ && rx_wp != rx_rp && !rx_known[rx_rp])
                it.action = ACT_PURGE;
            if (it.action == ACT_SERVICE && it.tx_ready && tx_wp != tx_rp && !tx_known[tx_rp])
                it.tx_ready = 1'b0;
            return it;
        endfunction

        // advance the mirrored state by one transfer and give its status
        function uart_status_t advance_rings(uart_item_t it);
            uart_status_t st;
            int unsigned  rlen, tlen, nx;
            bit [31:0]    level, room;

            st   = '{default: '0};
            rlen = ring_len(rx_size);
            tlen = ring_len(tx_size);
            case (it.action)
                ACT_SERVICE: begin
                    if (it.framing) fe_cnt = fe_cnt + 1;
                    if (it.parity)  pe_cnt = pe_cnt + 1;
                    if (it.noise)   ne_cnt = ne_cnt + 1;
                    if (it.overrun) oe_cnt = oe_cnt + 1;
                    // received byte is dropped when the ring is full
                    if (it.present) begin
                        nx = next_pos(rx_wp, rlen);
                        if (nx != rx_rp) begin
                            rx_mem[rx_wp]   = it.data;
                            rx_known[rx_wp] = 1'b1;
                            rx_wp           = nx;
                        end
                    end
                    // transmitter served on ready alone
                    if (it.tx_ready) begin
                        if (tx_rp == tx_wp) begin
                            tx_req = 1'b0;
                        end else begin
                            st.send_valid = 1'b1;
                            st.send_byte  = tx_mem[tx_rp];
                            tx_rp         = next_pos(tx_rp, tlen);
                        end
                    end
                end
                ACT_WRITE: begin
                    nx = next_pos(tx_wp, tlen);
                    if (nx != tx_rp) begin
                        tx_mem[tx_wp]   = it.data;
                        tx_known[tx_wp] = 1'b1;
                        tx_wp           = nx;
                        tx_req          = 1'b1;
                        st.write_ok     = 1'b1;
                    end
                end
                ACT_READ: begin
                    if (rx_wp != rx_rp) begin
                        st.read_valid = 1'b1;
                        st.read_byte  = rx_mem[rx_rp];
                        rx_rp         = next_pos(rx_rp, rlen);
                    end
                end
                default: begin
                    rx_wp = 0;
                    rx_rp = 0;
                end
            endcase

            // counts wrap modulo 2^32 when a position sits past a shrunk length
            if (rx_wp == rx_rp)
                level = 0;
            else if (rx_wp < rx_rp)
                level = rx_wp + rlen - rx_rp;
            else
                level = rx_wp - rx_rp;
            if (tx_wp == tx_rp)
                room = tlen - 1;
            else if (tx_rp < tx_wp)
                room = tx_rp + tlen - tx_wp - 1;
            else
                room = tx_rp - tx_wp - 1;

            st.tx_request = tx_req;
            st.rx_count   = level[BYTE_W-1:0];
            st.tx_free    = room[BYTE_W-1:0];
            st.framing    = fe_cnt;
            st.parity     = pe_cnt;
            st.noise      = ne_cnt;
            st.overrun    = oe_cnt;
            return st;
        endfunction

        function void note_item(uart_item_t it);
            status_q.push_back(advance_rings(it));
        endfunction

        function void field_ok(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            end
        endfunction

        function void check_status(uart_status_t got);
            uart_status_t want;
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t: status transfer with nothing expected", $time);
                return;
            end
            want = status_q.pop_front();
            field_ok("send_valid",     want.send_valid, got.send_valid);
            field_ok("send_byte",      want.send_byte,  got.send_byte);
            field_ok("read_valid",     want.read_valid, got.read_valid);
            field_ok("read_byte",      want.read_byte,  got.read_byte);
            field_ok("write_accepted", want.write_ok,   got.write_ok);
            field_ok("tx_request_on",  want.tx_request, got.tx_request);
            field_ok("rx_count",       want.rx_count,   got.rx_count);
            field_ok("tx_free",        want.tx_free,    got.tx_free);
            field_ok("framing_errors", want.framing,    got.framing);
            field_ok("parity_errors",  want.parity,     got.parity);
            field_ok("noise_errors",   want.noise,      got.noise);
            field_ok("overrun_errors", want.overrun,    got.overrun);
        endfunction

    endclass

endpackage

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UART ring buffer engine. A short directed run
// covers empty and full rings, every action and the error flags; random
// phases then sweep the ring sizes (clamped values included) with mixed
// fill and drain traffic and random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

    import urbe_pkg::*;
    import urbe_tb_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int ITEM_TARGET = 610;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_in_valid       = 1'b0;
    logic                 o_in_stall;
    logic [ACTION_W-1:0]  i_action         = '0;
    logic [BYTE_W-1:0]    i_data_byte      = '0;
    logic                 i_byte_present   = 1'b0;
    logic                 i_tx_ready       = 1'b0;
    logic                 i_framing_error  = 1'b0;
    logic                 i_parity_error   = 1'b0;
    logic                 i_noise_error    = 1'b0;
    logic                 i_overrun_error  = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall      = 1'b0;
    logic                 o_send_valid;
    logic [BYTE_W-1:0]    o_send_byte;
    logic                 o_read_valid;
    logic [BYTE_W-1:0]    o_read_byte;
    logic                 o_write_accepted;
    logic                 o_tx_request_on;
    logic [BYTE_W-1:0]    o_rx_count;
    logic [BYTE_W-1:0]    o_tx_free;
    logic [ERRCNT_W-1:0]  o_framing_errors;
    logic [ERRCNT_W-1:0]  o_parity_errors;
    logic [ERRCNT_W-1:0]  o_noise_errors;
    logic [ERRCNT_W-1:0]  o_overrun_errors;
    logic                 i_cfg_valid      = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index      = '0;
    logic [SIZE_W-1:0]    i_cfg_data       = '0;

    uart_ring_tracker tracker = new();

    bit no_idle     = 1'b0;
    int items_sent  = 0;
    int stall_left  = 0;
    int quiet       = 0;

    uart_ring_buffer_engine i_dut (.*);

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    function automatic uart_item_t make_item(input t_action act, input logic [7:0] data,
                                             input logic present, input logic ready,
                                             input logic [3:0] errs);
        uart_item_t it;
        it.action   = act;
        it.data     = data;
        it.present  = present;
        it.tx_ready = ready;
        {it.framing, it.parity, it.noise, it.overrun} = errs;
        return it;
    endfunction

    // bias 0 balanced, 1 fills the rings, 2 drains them
    function automatic uart_item_t random_item(input int bias);
        uart_item_t it;
        int roll, svc, wr;
        roll       = $urandom_range(0, 99);
        it.data    = 8'($urandom_range(0, 255));
        it.framing = ($urandom_range(0, 3) == 0);
        it.parity  = ($urandom_range(0, 3) == 0);
        it.noise   = ($urandom_range(0, 3) == 0);
        it.overrun = ($urandom_range(0, 3) == 0);
        case (bias)
            1: begin
                it.present  = ($urandom_range(0, 9) != 0);
                it.tx_ready = ($urandom_range(0, 6) == 0);
                svc = 50;
                wr  = 40;
            end
            2: begin
                it.present  = ($urandom_range(0, 2) == 0);
                it.tx_ready = ($urandom_range(0, 9) != 0);
                svc = 50;
                wr  = 10;
            end
            default: begin
                it.present  = ($urandom_range(0, 1) == 0);
                it.tx_ready = ($urandom_range(0, 1) == 0);
                svc = 45;
                wr  = 25;
            end
        endcase
        // purges kept rare so the receive ring gets a chance to fill
        if (roll < 3)
            it.action = ACT_PURGE;
        else if (roll < 3 + svc)
            it.action = ACT_SERVICE;
        else if (roll < 3 + svc + wr)
            it.action = ACT_WRITE;
        else
            it.action = ACT_READ;
        return it;
    endfunction

    // one input transfer after a random gap; valid stays up if no gap follows
    task automatic send_item(input uart_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it = tracker.make_safe(it);
        i_in_valid      <= 1'b1;
        i_action        <= it.action;
        i_data_byte     <= it.data;
        i_byte_present  <= it.present;
        i_tx_ready      <= it.tx_ready;
        i_framing_error <= it.framing;
        i_parity_error  <= it.parity;
        i_noise_error   <= it.noise;
        i_overrun_error <= it.overrun;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_item(it);
        items_sent++;
    endtask

    // hold off input until every status has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_ring_size(input t_cfg_idx idx, input logic [SIZE_W-1:0] size);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_size(idx, size);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // output side: check each status transfer, then stall for a while
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        uart_status_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.send_valid = o_send_valid;
            got.send_byte  = o_send_byte;
            got.read_valid = o_read_valid;
            got.read_byte  = o_read_byte;
            got.write_ok   = o_write_accepted;
            got.tx_request = o_tx_request_on;
            got.rx_count   = o_rx_count;
            got.tx_free    = o_tx_free;
            got.framing    = o_framing_errors;
            got.parity     = o_parity_errors;
            got.noise      = o_noise_errors;
            got.overrun    = o_overrun_errors;
            tracker.check_status(got);
            stall_left = no_idle ? 0 : $urandom_range(0, 3);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [SIZE_W-1:0] rx_plan [9];
        logic [SIZE_W-1:0] tx_plan [9];
        int phase, bias, n, guard;

        rx_plan = '{9'd3, 9'd0, 9'd17, 9'd511, 9'd256, 9'd1, 9'd40, 9'd2, 9'd255};
        tx_plan = '{9'd5, 9'd1, 9'd256, 9'd300, 9'd9, 9'd2, 9'd129, 9'd511, 9'd4};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty rings, byte extremes, each error flag, ignored fields
        send_item(make_item(ACT_READ,    8'h00, 1'b0, 1'b0, 4'b0000));
        send_item(make_item(ACT_SERVICE, 8'h00, 1'b0, 1'b1, 4'b1111));
        send_item(make_item(ACT_WRITE,   8'h00, 1'b0, 1'b0, 4'b0000));
        send_item(make_item(ACT_WRITE,   8'hff, 1'b0, 1'b0, 4'b0000));
        send_item(make_item(ACT_SERVICE, 8'hff, 1'b1, 1'b1, 4'b1000));
        send_item(make_item(ACT_SERVICE, 8'h00, 1'b1, 1'b0, 4'b0100));
        send_item(make_item(ACT_READ,    8'h00, 1'b0, 1'b0, 4'b0000));
        send_item(make_item(ACT_SERVICE, 8'h5a, 1'b1, 1'b1, 4'b0010));
        send_item(make_item(ACT_SERVICE, 8'h00, 1'b0, 1'b1, 4'b0001));
        send_item(make_item(ACT_READ,    8'h00, 1'b0, 1'b0, 4'b0000));
        send_item(make_item(ACT_PURGE,   8'h00, 1'b0, 1'b0, 4'b0000));
        send_item(make_item(ACT_READ,    8'hff, 1'b1, 1'b1, 4'b1111));
        send_item(make_item(ACT_WRITE,   8'hc3, 1'b1, 1'b1, 4'b1111));
        send_item(make_item(ACT_PURGE,   8'hff, 1'b1, 1'b1, 4'b1111));
        send_item(make_item(ACT_SERVICE, 8'h3c, 1'b1, 1'b1, 4'b0000));

        // directed: smallest rings, full transmit and full receive
        write_ring_size(CFG_RX_SIZE, 9'd2);
        write_ring_size(CFG_TX_SIZE, 9'd2);
        send_item(make_item(ACT_WRITE,   8'h11, 1'b0, 1'b0, 4'b0000));
        send_item(make_item(ACT_WRITE,   8'h22, 1'b0, 1'b0, 4'b0000));
        send_item(make_item(ACT_SERVICE, 8'h80, 1'b1, 1'b0, 4'b0000));
        send_item(make_item(ACT_SERVICE, 8'h01, 1'b1, 1'b0, 4'b0000));
        send_item(make_item(ACT_READ,    8'h00, 1'b0, 1'b0, 4'b0000));
        send_item(make_item(ACT_SERVICE, 8'h00, 1'b0, 1'b1, 4'b0000));
        send_item(make_item(ACT_SERVICE, 8'h00, 1'b0, 1'b1, 4'b0000));
        send_item(make_item(ACT_WRITE,   8'h33, 1'b0, 1'b0, 4'b0000));
        send_item(make_item(ACT_WRITE,   8'h44, 1'b0, 1'b0, 4'b0000));

        // random phases, each under its own pair of ring sizes
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            // transmit ring is emptied before its size moves
            no_idle = 1'b0;
            guard   = 0;
            while (tracker.tx_wp != tracker.tx_rp && guard < 300) begin
                uart_item_t it;
                it          = random_item(0);
                it.action   = ACT_SERVICE;
                it.tx_ready = 1'b1;
                send_item(it);
                guard++;
            end
            write_ring_size(CFG_RX_SIZE, rx_plan[phase % 9]);
            write_ring_size(CFG_TX_SIZE, tx_plan[phase % 9]);

            no_idle = (phase % 4 == 1);
            bias    = $urandom_range(0, 2);
            for (n = 0; n < 60; n++) begin
                // half way through, switch from filling to draining, else to filling
                if (n == 30)
                    bias = (bias == 1) ? 2 : 1;
                send_item(random_item(bias));
            end
            phase++;
        end

        no_idle = 1'b0;
        wait_for_results();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/urbe_pkg.sv
rtl/core/urbe_ram.sv
rtl/core/urbe_ring.sv
rtl/core/uart_ring_buffer_engine.sv
tb/urbe_tb_pkg.sv
tb/tb.sv
